// ===== rtl/qmdd_pkg.sv =====
// Shared types and constants of the QAM minimum-distance demapper.
package qmdd_pkg;

  localparam int unsigned CoordWidth  = 16;
  localparam int unsigned DistWidth   = 2 * CoordWidth + 1;
  localparam int unsigned LabelWidth  = 6;
  localparam int unsigned EntryWidth  = 6;
  localparam int unsigned IdxWidth    = 8;
  localparam int unsigned BpsWidth    = 3;
  localparam int unsigned NptsWidth   = 7;
  localparam int unsigned CfgWidth    = 7;
  localparam int unsigned MaxPointsDefault = 64;
  localparam int unsigned BpsMax      = 6;

  localparam logic [BpsWidth-1:0]  BpsReset  = 3'd2;
  localparam logic [NptsWidth-1:0] NptsReset = 7'd4;

  // Configuration register indexes
  localparam logic CfgBitsPerSymbol = 1'b0;
  localparam logic CfgNumPoints     = 1'b1;

  // Request codes
  localparam logic ReqLoad   = 1'b0;
  localparam logic ReqSample = 1'b1;

  typedef struct packed {
    logic                         req_type;
    logic [EntryWidth-1:0]        entry_index;
    logic signed [CoordWidth-1:0] point_i;
    logic signed [CoordWidth-1:0] point_q;
    logic [LabelWidth-1:0]        point_label;
    logic signed [CoordWidth-1:0] sample_i;
    logic signed [CoordWidth-1:0] sample_q;
    logic                         last_sample;
  } in_item_t;

  typedef struct packed {
    logic [EntryWidth-1:0] symbol_index;
    logic [LabelWidth-1:0] data_bits;
    logic                  end_of_block;
  } out_item_t;

  // Item traveling down the point chain with its running best match
  typedef struct packed {
    logic                  valid;
    in_item_t              item;
    logic [DistWidth-1:0]  best_d;
    logic [IdxWidth-1:0]   best_idx;
    logic [LabelWidth-1:0] best_label;
  } pipe_t;

endpackage

// ===== rtl/qmdd_cell.sv =====
// One constellation point: stored coordinates, distance and running minimum.
module qmdd_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic [qmdd_pkg::NptsWidth-1:0]      num_points_i,
  input  qmdd_pkg::pipe_t                     pipe_i,
  output qmdd_pkg::pipe_t                     pipe_o
);

  logic signed [qmdd_pkg::CoordWidth-1:0] pt_i_q, pt_q_q;
  logic [qmdd_pkg::LabelWidth-1:0]        lbl_q;

  qmdd_pkg::pipe_t                        a_q;
  logic                                   a_valid_q;
  logic [2*qmdd_pkg::CoordWidth-1:0]      sq_i_q, sq_q_q, sq_i_d, sq_q_d;
  logic [qmdd_pkg::LabelWidth-1:0]        lbl_a_q;

  qmdd_pkg::pipe_t                        b_q, b_d;
  logic                                   b_valid_q;

  logic signed [qmdd_pkg::CoordWidth:0]   diff_i, diff_q;
  logic [qmdd_pkg::CoordWidth-1:0]        mag_i, mag_q;
  logic [qmdd_pkg::DistWidth-1:0]         sq_dist;
  logic                                   take;
  logic                                   load_hit;

  assign load_hit = en_i && pipe_i.valid && (pipe_i.item.req_type == qmdd_pkg::ReqLoad)
                    && (32'(pipe_i.item.entry_index) == 32'(CellIdx));

  // Table entry: written when a load reaches this cell, so order is kept
  always_ff @(posedge clk_i) begin
    if (load_hit) begin
      pt_i_q <= pipe_i.item.point_i;
      pt_q_q <= pipe_i.item.point_q;
      lbl_q  <= pipe_i.item.point_label;
    end
  end

  always_comb begin
    diff_i = {pipe_i.item.sample_i[qmdd_pkg::CoordWidth-1], pipe_i.item.sample_i}
           - {pt_i_q[qmdd_pkg::CoordWidth-1], pt_i_q};
    diff_q = {pipe_i.item.sample_q[qmdd_pkg::CoordWidth-1], pipe_i.item.sample_q}
           - {pt_q_q[qmdd_pkg::CoordWidth-1], pt_q_q};
    mag_i  = diff_i[qmdd_pkg::CoordWidth] ? qmdd_pkg::CoordWidth'(-diff_i)
                                          : qmdd_pkg::CoordWidth'(diff_i);
    mag_q  = diff_q[qmdd_pkg::CoordWidth] ? qmdd_pkg::CoordWidth'(-diff_q)
                                          : qmdd_pkg::CoordWidth'(diff_q);
    sq_i_d = mag_i * mag_i;
    sq_q_d = mag_q * mag_q;
  end

  // Stage A: squares
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= pipe_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q     <= pipe_i;
      sq_i_q  <= sq_i_d;
      sq_q_q  <= sq_q_d;
      lbl_a_q <= lbl_q;
    end
  end

  // Stage B: add and compare
  always_comb begin
    sq_dist = {1'b0, sq_i_q} + {1'b0, sq_q_q};
    take = (CellIdx == 0) ||
           ((32'(CellIdx) < 32'(num_points_i)) && (sq_dist < a_q.best_d));
    b_d       = a_q;
    b_d.valid = a_valid_q;
    if (take) begin
      b_d.best_d     = sq_dist;
      b_d.best_idx   = qmdd_pkg::IdxWidth'(CellIdx);
      b_d.best_label = lbl_a_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_q <= b_d;
    end
  end

  always_comb begin
    pipe_o       = b_q;
    pipe_o.valid = b_valid_q;
  end

  a_first_cell_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CellIdx == 0 && en_i && a_valid_q) |=> (b_q.best_idx == '0))
    else $error("first cell did not take its own point");

  // Loads carry no sample, so only sample items are tracked here
  a_best_not_worse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CellIdx != 0 && en_i && a_valid_q && a_q.item.req_type == qmdd_pkg::ReqSample)
    |=> (b_q.best_d <= $past(a_q.best_d)))
    else $error("running minimum grew");

  a_idx_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && b_q.item.req_type == qmdd_pkg::ReqSample)
    |-> (32'(b_q.best_idx) <= 32'(CellIdx)))
    else $error("best index beyond this cell");

endmodule

// ===== rtl/qmdd_decode.sv =====
// Gray-to-binary decode of the winning label and the output register.
module qmdd_decode (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic [qmdd_pkg::BpsWidth-1:0]     bps_i,
  input  qmdd_pkg::pipe_t                   pipe_i,
  output logic                              out_valid_o,
  output qmdd_pkg::out_item_t               out_o
);

  logic [qmdd_pkg::BpsWidth-1:0]   bps_sat;
  logic [qmdd_pkg::LabelWidth:0]   mask;
  logic [qmdd_pkg::LabelWidth-1:0] gray, bin;
  logic                            valid_q, valid_d;
  qmdd_pkg::out_item_t             res_q, res_d;

  always_comb begin
    bps_sat = (bps_i > qmdd_pkg::BpsWidth'(qmdd_pkg::BpsMax))
              ? qmdd_pkg::BpsWidth'(qmdd_pkg::BpsMax) : bps_i;
    mask    = (7'd1 << bps_sat) - 7'd1;
    gray    = pipe_i.best_label & mask[qmdd_pkg::LabelWidth-1:0];
    bin[qmdd_pkg::LabelWidth-1] = gray[qmdd_pkg::LabelWidth-1];
    for (int k = qmdd_pkg::LabelWidth - 2; k >= 0; k--) begin
      bin[k] = bin[k+1] ^ gray[k];
    end
    valid_d            = pipe_i.valid && (pipe_i.item.req_type == qmdd_pkg::ReqSample);
    res_d.symbol_index = pipe_i.best_idx[qmdd_pkg::EntryWidth-1:0];
    res_d.data_bits    = bin;
    res_d.end_of_block = pipe_i.item.last_sample;
  end

  // Drop load items here: they carry no result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule

// ===== rtl/qam_min_distance_demapper_core.sv =====
// Top level of the QAM minimum-distance demapper.
// Accepts one item per cycle while the output is not stalled, loads and samples alike,
// and returns one result per sample item once it has passed the whole chain: each
// constellation point is a cell of two register stages (squares, then add and
// compare) and the chain ends in the Gray decode output register. Loads flow down
// the same chain and write their point when they reach its cell, so every sample
// sees exactly the loads ahead of it. A stall at the output holds the whole chain.
module qam_min_distance_demapper_core #(
  parameter int unsigned MAX_POINTS = qmdd_pkg::MaxPointsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  qmdd_pkg::in_item_t            in_i,
  output logic                          in_stall_o,
  output logic                          out_valid_o,
  output qmdd_pkg::out_item_t           out_o,
  input  logic                          out_stall_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [qmdd_pkg::CfgWidth-1:0] cfg_data_i
);

  logic [qmdd_pkg::BpsWidth-1:0]  bps_q;
  logic [qmdd_pkg::NptsWidth-1:0] npts_q;
  logic                           en;
  qmdd_pkg::pipe_t                chain [MAX_POINTS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bps_q  <= qmdd_pkg::BpsReset;
      npts_q <= qmdd_pkg::NptsReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        qmdd_pkg::CfgBitsPerSymbol: bps_q  <= cfg_data_i[qmdd_pkg::BpsWidth-1:0];
        qmdd_pkg::CfgNumPoints:     npts_q <= cfg_data_i[qmdd_pkg::NptsWidth-1:0];
        default: ;
      endcase
    end
  end

  // Advance unless a result waits at a stalled output
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  always_comb begin
    chain[0].valid      = in_valid_i;
    chain[0].item       = in_i;
    chain[0].best_d     = '0;
    chain[0].best_idx   = '0;
    chain[0].best_label = '0;
  end

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    qmdd_cell #(
      .CellIdx(g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en),
      .num_points_i(npts_q),
      .pipe_i      (chain[g]),
      .pipe_o      (chain[g+1])
    );
  end

  qmdd_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .bps_i      (bps_q),
    .pipe_i     (chain[MAX_POINTS]),
    .out_valid_o(out_valid_o),
    .out_o      (out_o)
  );

  a_stall_only_on_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  a_load_gives_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && chain[MAX_POINTS].valid && chain[MAX_POINTS].item.req_type == qmdd_pkg::ReqLoad)
    |=> !out_valid_o)
    else $error("load item produced a result");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_o)))
    else $error("stalled result changed");

endmodule

// ===== test/qam_min_distance_demapper_core_checker.sv =====
// Checker for the QAM demapper: tracks the tables and registers, predicts, compares.
`timescale 1ns / 1ps
module qam_min_distance_demapper_core_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  qmdd_pkg::in_item_t            in_i,
  input  logic                          in_stall_i,
  input  logic                          out_valid_i,
  input  qmdd_pkg::out_item_t           out_i,
  input  logic                          out_stall_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [qmdd_pkg::CfgWidth-1:0] cfg_data_i,
  output int                            mismatches_o,
  output int                            pending_o
);

  logic signed [qmdd_pkg::CoordWidth-1:0] tbl_i [64];
  logic signed [qmdd_pkg::CoordWidth-1:0] tbl_q [64];
  logic [qmdd_pkg::LabelWidth-1:0]        tbl_label [64];
  logic [qmdd_pkg::BpsWidth-1:0]          bps;
  logic [qmdd_pkg::NptsWidth-1:0]         npts;
  qmdd_pkg::out_item_t                    decisions_q [$];

  function automatic qmdd_pkg::out_item_t nearest_point(qmdd_pkg::in_item_t s);
    qmdd_pkg::out_item_t r;
    int unsigned n, m, best;
    longint di, dq, d, best_d;
    logic [qmdd_pkg::LabelWidth-1:0] g;
    n = (npts > 64) ? 64 : npts;
    m = (bps > qmdd_pkg::BpsMax) ? qmdd_pkg::BpsMax : bps;
    best = 0;
    best_d = 0;
    for (int unsigned j = 0; j < n; j++) begin
      di = longint'(tbl_i[j]) - longint'(s.sample_i);
      dq = longint'(tbl_q[j]) - longint'(s.sample_q);
      d = di * di + dq * dq;
      if (j == 0 || d < best_d) begin
        best_d = d;
        best = j;
      end
    end
    // keep only the low m label bits, then undo the Gray code
    g = qmdd_pkg::LabelWidth'(tbl_label[best] & ((7'd1 << m) - 7'd1));
    g ^= g >> 1;
    g ^= g >> 2;
    g ^= g >> 4;
    r.symbol_index = best[qmdd_pkg::EntryWidth-1:0];
    r.data_bits    = g;
    r.end_of_block = s.last_sample;
    return r;
  endfunction

  assign pending_o = decisions_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    qmdd_pkg::out_item_t exp_r;
    if (!rst_ni) begin
      bps <= qmdd_pkg::BpsReset;
      npts <= qmdd_pkg::NptsReset;
      mismatches_o <= 0;
      decisions_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == qmdd_pkg::CfgBitsPerSymbol) bps <= cfg_data_i[qmdd_pkg::BpsWidth-1:0];
        else npts <= cfg_data_i[qmdd_pkg::NptsWidth-1:0];
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_i.req_type == qmdd_pkg::ReqLoad) begin
          tbl_i[in_i.entry_index]     = in_i.point_i;
          tbl_q[in_i.entry_index]     = in_i.point_q;
          tbl_label[in_i.entry_index] = in_i.point_label;
        end else begin
          decisions_q.push_back(nearest_point(in_i));
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (decisions_q.size() == 0) begin
          mismatches_o <= mismatches_o + 1;
          if (mismatches_o < 10)
            $display("%0t: unexpected item idx=%0d bits=%0h eob=%0b", $realtime,
                     out_i.symbol_index, out_i.data_bits, out_i.end_of_block);
        end else begin
          exp_r = decisions_q.pop_front();
          if (exp_r !== out_i) begin
            mismatches_o <= mismatches_o + 1;
            if (mismatches_o < 10)
              $display("%0t: mismatch idx %0d/%0d bits %0h/%0h eob %0b/%0b (exp/act)",
                       $realtime, exp_r.symbol_index, out_i.symbol_index,
                       exp_r.data_bits, out_i.data_bits,
                       exp_r.end_of_block, out_i.end_of_block);
          end
        end
      end
    end
  end
endmodule

// ===== test/qam_min_distance_demapper_core_tb.sv =====
// Testbench top for the QAM demapper: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module qam_min_distance_demapper_core_tb;

  localparam int Latency = 2 * 64 + 1;
  localparam int WatchLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  qmdd_pkg::in_item_t  in_item = '0;
  logic        in_stall;
  logic        out_valid;
  qmdd_pkg::out_item_t out_item;
  logic        out_stall = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = qmdd_pkg::CfgBitsPerSymbol;
  logic [qmdd_pkg::CfgWidth-1:0] cfg_data = '0;
  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  logic        steady = 1'b0;
  int          hold_req = 0;
  int          hold_left = 0;
  int          mismatches, pending;
  int          quiet_cycles = 0;

  qam_min_distance_demapper_core DUT (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_i(in_item), .in_stall_o(in_stall),
    .out_valid_o(out_valid), .out_o(out_item), .out_stall_i(out_stall),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  qam_min_distance_demapper_core_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_i(in_item), .in_stall_i(in_stall),
    .out_valid_i(out_valid), .out_i(out_item), .out_stall_i(out_stall),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .mismatches_o(mismatches), .pending_o(pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    in_fire  <= in_valid && !in_stall;
    out_fire <= out_valid && !out_stall;
  end

  // receiver: random stalls, or one long hold when asked
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 29);
    end
  end

  always @(posedge clk_i) begin
    if (in_fire || out_fire) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // 8-level axis of a 64-point grid, Gray-coded per axis
  function automatic logic signed [15:0] grid_level(int k);
    return 16'(((2 * k) - 7) * 4096);
  endfunction

  function automatic qmdd_pkg::in_item_t load_item(int e, logic signed [15:0] pi,
                                                   logic signed [15:0] pq, logic [5:0] lbl);
    qmdd_pkg::in_item_t it;
    it = qmdd_pkg::in_item_t'({$urandom, $urandom, $urandom});
    it.req_type    = qmdd_pkg::ReqLoad;
    it.entry_index = 6'(e);
    it.point_i     = pi;
    it.point_q     = pq;
    it.point_label = lbl;
    return it;
  endfunction

  function automatic qmdd_pkg::in_item_t sample_item(logic signed [15:0] si,
                                                     logic signed [15:0] sq);
    qmdd_pkg::in_item_t it;
    it = qmdd_pkg::in_item_t'({$urandom, $urandom, $urandom});
    it.req_type    = qmdd_pkg::ReqSample;
    it.sample_i    = si;
    it.sample_q    = sq;
    it.last_sample = ($urandom_range(7) == 0);
    return it;
  endfunction

  task automatic send(qmdd_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(negedge clk_i); while (!in_fire);
    if (!steady && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
  endtask

  task automatic write_reg(logic idx, int val);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    // loads produce nothing, so let the chain drain fully
    repeat (Latency + 10) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= qmdd_pkg::CfgWidth'(val);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic fill_grid();
    for (int a = 0; a < 8; a++)
      for (int b = 0; b < 8; b++)
        send(load_item(a * 8 + b, grid_level(a), grid_level(b),
                       {3'(a ^ (a >> 1)), 3'(b ^ (b >> 1))}));
  endtask

  function automatic qmdd_pkg::in_item_t random_item();
    int r;
    logic signed [15:0] si, sq;
    r = $urandom_range(99);
    if (r < 12)
      return load_item($urandom_range(63), 16'($urandom), 16'($urandom), 6'($urandom));
    if (r < 16)  // duplicate point: equal distances, lower index must win
      return load_item($urandom_range(63), grid_level($urandom_range(7)),
                       grid_level($urandom_range(7)), 6'($urandom));
    if (r < 55) begin
      si = grid_level($urandom_range(7)) + 16'($signed($urandom_range(4000)) - 2000);
      sq = grid_level($urandom_range(7)) + 16'($signed($urandom_range(4000)) - 2000);
    end else if (r < 70) begin
      // midpoints between grid levels (the top step wraps to -32768)
      si = 16'(($signed($urandom_range(7)) - 3) * 8192);
      sq = 16'(($signed($urandom_range(7)) - 3) * 8192);
    end else begin
      si = 16'($urandom);
      sq = 16'($urandom);
    end
    return sample_item(si, sq);
  endfunction

  initial begin
    int bps_set [8] = '{2, 0, 7, 6, 1, 4, 3, 5};
    int np_set  [8] = '{4, 0, 127, 64, 1, 16, 37, 100};
    int n_items;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    fill_grid();

    // directed: extremes, ties and extreme points under reset settings
    send(sample_item(16'sh8000, 16'sh8000));
    send(sample_item(16'sh7fff, 16'sh7fff));
    send(sample_item(16'sh0000, 16'sh0000));
    send(sample_item(16'sh8000, 16'sh7fff));
    send(sample_item(grid_level(0), 16'(-4 * 4096)));
    send(load_item(2, 16'sh8000, 16'sh7fff, 6'h3f));
    send(sample_item(16'sh8000, 16'sh7fff));
    send(load_item(3, 16'sh8000, 16'sh7fff, 6'h2a));
    send(sample_item(16'sh8000, 16'sh7fff));
    send(load_item(1, 16'sh7fff, 16'sh8000, 6'h15));
    send(sample_item(16'sh7fff, 16'sh8000));
    send(sample_item(16'sh7fff, 16'sh7fff));
    fill_grid();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph > 0) begin
        write_reg(qmdd_pkg::CfgBitsPerSymbol, (ph < 8) ? bps_set[ph] : $urandom_range(7));
        write_reg(qmdd_pkg::CfgNumPoints, (ph < 8) ? np_set[ph] : $urandom_range(127));
      end
      // enough items under the long hold to fill the chain and stall the input
      n_items = (ph == 3) ? 130 : (ph == 5) ? 80 : 10;
      steady = (ph == 5);
      if (ph == 3) hold_req = 400;
      for (int k = 0; k < n_items; k++) send(random_item());
      steady = 1'b0;
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 10) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
